/* rtl/core/adc_sample_autocal_normalizer_assert.svh */
// Assertion macros shared by the normalizer RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef ADC_SAMPLE_AUTOCAL_NORMALIZER_ASSERT_SVH
`define ADC_SAMPLE_AUTOCAL_NORMALIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASN_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASN_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The condition must never be seen at a clock edge.
`define ASN_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* rtl/core/adcnorm_pkg.sv */
// Package for the converter sample normalizer: widths, codes and shared types.
// No dependencies; the other RTL modules and the interfaces all use it.
package adcnorm_pkg;

	localparam int TS_W       = 32;
	localparam int SAMPLE_W   = 12;
	localparam int VREF_W     = 16;
	localparam int VOLT_W     = 16;
	localparam int FRAC_W     = 16;
	localparam int NORM_W     = FRAC_W + 1;
	localparam int FULL_SCALE = 4095;
	localparam int FS_W       = $clog2(FULL_SCALE + 1);
	localparam int BND_W      = (FS_W > SAMPLE_W) ? FS_W : SAMPLE_W;
	localparam int DIV_W      = SAMPLE_W + FRAC_W;
	localparam int STEP_W     = $clog2(DIV_W);
	localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
	localparam int MIN_RST    = (FULL_SCALE > SAMPLE_MAX) ? SAMPLE_MAX : FULL_SCALE;

	// The millivolt value divides the held sample times vref by FULL_SCALE. The
	// rounded-up reciprocal with FS_W extra bits of shift gives the exact floor
	// for every product that fits in VPROD_W bits.
	localparam int VPROD_W  = SAMPLE_W + VREF_W;
	localparam int VSHIFT   = VPROD_W + FS_W;
	localparam int VRECIP_W = VPROD_W + 1;
	localparam logic [VRECIP_W-1:0] VRECIP =
		VRECIP_W'(((64'd1 << VSHIFT) + 64'(FULL_SCALE - 1)) / 64'(FULL_SCALE));

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [NORM_W-1:0] ONE_Q16 = NORM_W'(1) << FRAC_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PERIOD_US = 3'd0,
		REG_AUTO_CAL  = 3'd1,
		REG_FIXED_MIN = 3'd2,
		REG_FIXED_MAX = 3'd3,
		REG_VREF_MV   = 3'd4
	} cfg_idx_e;

	typedef enum logic [1:0] {
		NK_DIV,
		NK_ZERO,
		NK_ONE
	} norm_kind_e;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_DONE
	} back_state_e;

	typedef struct packed {
		logic [TS_W-1:0]     period_us;
		logic                auto_cal;
		logic [SAMPLE_W-1:0] fixed_min;
		logic [SAMPLE_W-1:0] fixed_max;
		logic [VREF_W-1:0]   vref_mv;
	} cfg_t;

	// One classified item waiting for the divider.
	typedef struct packed {
		logic [SAMPLE_W-1:0] held;
		logic                captured;
		logic                clipped;
		norm_kind_e          kind;
		logic [SAMPLE_W-1:0] num;
		logic [BND_W-1:0]    den;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

/* rtl/core/adcnorm_ifs.sv */
// Valid/ready channel interfaces for the normalizer: input, result and configuration.
// Depends on adcnorm_pkg for field widths.
interface adcnorm_in_if;
	logic                             valid;
	logic                             ready;
	logic [adcnorm_pkg::TS_W-1:0]     now_us;
	logic [adcnorm_pkg::SAMPLE_W-1:0] adc_sample;

	modport source (output valid, output now_us, output adc_sample, input ready);
	modport sink (input valid, input now_us, input adc_sample, output ready);
endinterface

interface adcnorm_out_if;
	logic                             valid;
	logic                             ready;
	logic [adcnorm_pkg::SAMPLE_W-1:0] held_sample;
	logic                             captured;
	logic [adcnorm_pkg::NORM_W-1:0]   norm_q16;
	logic                             clipped;
	logic [adcnorm_pkg::VOLT_W-1:0]   voltage_mv;

	modport source (output valid, output held_sample, output captured, output norm_q16,
		output clipped, output voltage_mv, input ready);
	modport sink (input valid, input held_sample, input captured, input norm_q16,
		input clipped, input voltage_mv, output ready);
endinterface

interface adcnorm_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [adcnorm_pkg::CFG_IDX_W-1:0]  index;
	logic [adcnorm_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/adc_sample_autocal_normalizer.sv */
// Top level of the converter sample normalizer: configuration registers and the
// front end, queue and divider back end. Depends on adcnorm_pkg and adcnorm_ifs.
//
// Channels: in_ch takes one beat per converter reading (now_us, adc_sample);
// out_ch gives one result beat per input beat, in order (held_sample, captured,
// norm_q16, clipped, voltage_mv). cfg_ch writes register index/data and is
// always ready; write it only while no item is in flight.
// With the back end idle, an input beat goes through the queue and the back end's idle,
// multiply, divide and done states to the out_ch register. The back end works on one
// item at a time, paced by the 28 iterations of its bit-serial ratio divider. The front
// end takes up to two more beats into its queue meanwhile, then drops in_ch.ready.
// Reset: the registers return to their defaults (period 0, fixed bounds,
// window 0..4095, 3300 mV), the held sample and last capture time clear,
// the running minimum goes to full scale and the running maximum to zero.
// When the receiver stalls, the result stays on out_ch, the back end waits
// with its next result, and the queue fills before in_ch.ready falls.
module adc_sample_autocal_normalizer (
	input  logic          clk,
	input  logic          arst_n,
	adcnorm_in_if.sink    in_ch,
	adcnorm_out_if.source out_ch,
	adcnorm_cfg_if.sink   cfg_ch
);
	import adcnorm_pkg::*;

	logic [TS_W-1:0]     period_q;
	logic                auto_cal_q;
	logic [SAMPLE_W-1:0] fixed_min_q;
	logic [SAMPLE_W-1:0] fixed_max_q;
	logic [VREF_W-1:0]   vref_q;

	cfg_t       cfg;
	fifo_stat_t stat;
	item_t      fr_item;
	item_t      head;
	logic       push;
	logic       pop;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			auto_cal_q <= 1'b0;
			fixed_min_q <= '0;
			fixed_max_q <= SAMPLE_W'(4095);
			vref_q <= VREF_W'(3300);
		end else if (cfg_ch.valid) begin
			case (cfg_idx_e'(cfg_ch.index))
				REG_PERIOD_US: period_q <= cfg_ch.data[TS_W-1:0];
				REG_AUTO_CAL:  auto_cal_q <= cfg_ch.data[0];
				REG_FIXED_MIN: fixed_min_q <= cfg_ch.data[SAMPLE_W-1:0];
				REG_FIXED_MAX: fixed_max_q <= cfg_ch.data[SAMPLE_W-1:0];
				REG_VREF_MV:   vref_q <= cfg_ch.data[VREF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.period_us = period_q;
	assign cfg.auto_cal = auto_cal_q;
	assign cfg.fixed_min = fixed_min_q;
	assign cfg.fixed_max = fixed_max_q;
	assign cfg.vref_mv = vref_q;

	adcnorm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.stat   (stat),
		.push   (push),
		.item   (fr_item)
	);

	adcnorm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (fr_item),
		.pop     (pop),
		.head    (head),
		.stat    (stat)
	);

	adcnorm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.stat    (stat),
		.vref_mv (cfg.vref_mv),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

/* rtl/core/adcnorm_front.sv */
// Front end: accepts input beats, applies the capture interval, tracks calibration
// bounds and classifies each item for the divider. Depends on adcnorm_pkg, adcnorm_ifs.
module adcnorm_front (
	input  logic                    clk,
	input  logic                    arst_n,
	adcnorm_in_if.sink              in_ch,
	input  adcnorm_pkg::cfg_t       cfg,
	input  adcnorm_pkg::fifo_stat_t stat,
	output logic                    push,
	output adcnorm_pkg::item_t      item
);
	import adcnorm_pkg::*;

	logic [TS_W-1:0]     last_q;
	logic [SAMPLE_W-1:0] held_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;

	logic [TS_W-1:0]     elapsed;
	logic                cap;
	logic [SAMPLE_W-1:0] held_n;
	logic [SAMPLE_W-1:0] min_n;
	logic [SAMPLE_W-1:0] max_n;
	logic                swap;
	logic [BND_W-1:0]    lo;
	logic [BND_W-1:0]    hi;
	logic [BND_W-1:0]    held_b;

	assign in_ch.ready = !stat.full;
	assign push = in_ch.valid && in_ch.ready;

	always_comb begin
		elapsed = in_ch.now_us - last_q;
		cap = (elapsed >= cfg.period_us);
		held_n = cap ? in_ch.adc_sample : held_q;
		max_n = (held_n > max_q) ? held_n : max_q;
		min_n = (held_n < min_q) ? held_n : min_q;
		// An empty or inverted fixed window falls back to the full converter range.
		swap = (cfg.fixed_min >= cfg.fixed_max);
		lo = swap ? '0 : BND_W'(cfg.fixed_min);
		hi = swap ? BND_W'(FULL_SCALE) : BND_W'(cfg.fixed_max);
		held_b = BND_W'(held_n);

		item.held = held_n;
		item.captured = cap;
		item.clipped = 1'b0;
		item.kind = NK_ZERO;
		item.num = '0;
		item.den = '0;
		if (cfg.auto_cal) begin
			if (max_n > min_n) begin
				item.kind = NK_DIV;
				item.num = held_n - min_n;
				item.den = BND_W'(max_n - min_n);
			end
		end else if (held_b < lo) begin
			item.clipped = 1'b1;
		end else if (held_b > hi) begin
			item.kind = NK_ONE;
			item.clipped = 1'b1;
		end else begin
			item.kind = NK_DIV;
			item.num = SAMPLE_W'(held_b - lo);
			item.den = hi - lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			held_q <= '0;
			min_q <= SAMPLE_W'(MIN_RST);
			max_q <= '0;
		end else if (push) begin
			if (cap) begin
				last_q <= in_ch.now_us;
				held_q <= in_ch.adc_sample;
			end
			if (cfg.auto_cal) begin
				min_q <= min_n;
				max_q <= max_n;
			end
		end
	end

endmodule

/* rtl/core/adcnorm_fifo.sv */
// Short register queue between the front end and the divider back end.
// Depends on adcnorm_pkg and the assertion macro header.
`include "adc_sample_autocal_normalizer_assert.svh"

module adcnorm_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  adcnorm_pkg::item_t      wr_item,
	input  logic                    pop,
	output adcnorm_pkg::item_t      head,
	output adcnorm_pkg::fifo_stat_t stat
);
	import adcnorm_pkg::*;

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	assign head = mem_q[rd_q];
	assign stat.full = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASN_NEVER(a_fifo_cnt_range, cnt_q > FIFO_CNT_W'(FIFO_DEPTH), "fifo count beyond depth")
	`ASN_NEVER(a_fifo_pop_empty, pop && stat.empty, "fifo popped while empty")
	`ASN_NEVER(a_fifo_push_full, push && stat.full, "fifo pushed while full")

endmodule

/* rtl/core/adcnorm_back.sv */
// Back end: bit-serial divider for the Q1.16 ratio, reciprocal multiply for the
// millivolt value, plus the result register. Depends on adcnorm_pkg, adcnorm_ifs, macros.
`include "adc_sample_autocal_normalizer_assert.svh"

module adcnorm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  adcnorm_pkg::item_t            head,
	input  adcnorm_pkg::fifo_stat_t       stat,
	input  logic [adcnorm_pkg::VREF_W-1:0] vref_mv,
	output logic                          pop,
	adcnorm_out_if.source                 out_ch
);
	import adcnorm_pkg::*;

	back_state_e         state_q;
	back_state_e         state_d;
	logic                load_out;

	item_t               item_q;
	logic [STEP_W-1:0]   step_q;
	logic [DIV_W-1:0]    ndvd_q;
	logic [BND_W-1:0]    nrem_q;
	logic [DIV_W-1:0]    nquo_q;
	logic [VPROD_W-1:0]  vdvd_q;
	logic [VPROD_W-1:0]  vquo_q;

	logic [BND_W:0]      ntrial;
	logic                nbit;
	logic [VPROD_W+VRECIP_W-1:0] vprod;
	logic [NORM_W-1:0]   norm_fin;
	logic [VOLT_W-1:0]   volt_fin;

	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_held_q;
	logic                out_cap_q;
	logic [NORM_W-1:0]   out_norm_q;
	logic                out_clip_q;
	logic [VOLT_W-1:0]   out_volt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!stat.empty) begin
					pop = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (step_q == STEP_W'(DIV_W - 1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				// Wait here while an earlier result is still held by the receiver.
				if (!out_valid_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Restoring division for the ratio, one quotient bit per cycle. The millivolt
	// quotient comes from one multiply by the reciprocal of full scale.
	always_comb begin
		ntrial = {nrem_q, ndvd_q[DIV_W-1]};
		nbit = (ntrial >= {1'b0, item_q.den});
		vprod = (VPROD_W + VRECIP_W)'(vdvd_q) * (VPROD_W + VRECIP_W)'(VRECIP);
		case (item_q.kind)
			NK_DIV: norm_fin = nquo_q[NORM_W-1:0];
			NK_ONE: norm_fin = ONE_Q16;
			default: norm_fin = '0;
		endcase
		volt_fin = (|vquo_q[VPROD_W-1:VOLT_W]) ? '1 : vquo_q[VOLT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
		case (state_q)
			BK_MUL: begin
				step_q <= '0;
				ndvd_q <= {item_q.num, FRAC_W'(0)};
				nrem_q <= '0;
				nquo_q <= '0;
				vdvd_q <= VPROD_W'(item_q.held) * VPROD_W'(vref_mv);
				vquo_q <= '0;
			end
			BK_DIV: begin
				step_q <= step_q + 1'b1;
				ndvd_q <= ndvd_q << 1;
				nrem_q <= nbit ? BND_W'(ntrial - {1'b0, item_q.den}) : ntrial[BND_W-1:0];
				nquo_q <= {nquo_q[DIV_W-2:0], nbit};
				vquo_q <= VPROD_W'(vprod >> VSHIFT);
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_held_q <= item_q.held;
			out_cap_q <= item_q.captured;
			out_norm_q <= norm_fin;
			out_clip_q <= item_q.clipped;
			out_volt_q <= volt_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.held_sample = out_held_q;
	assign out_ch.captured = out_cap_q;
	assign out_ch.norm_q16 = out_norm_q;
	assign out_ch.clipped = out_clip_q;
	assign out_ch.voltage_mv = out_volt_q;

	`ASN_IMPLY(a_back_pop_idle, pop, state_q == BK_IDLE, "pop outside idle")
	`ASN_NEXT(a_back_div_start, state_q == BK_MUL, state_q == BK_DIV && step_q == '0,
		"divider did not start from step zero")
	`ASN_IMPLY(a_back_den_nonzero, state_q == BK_DIV && item_q.kind == NK_DIV,
		item_q.den != '0, "division by zero in ratio divider")

endmodule

/* tb/sv/adcnorm_tb_pkg.sv */
`timescale 1ns / 1ps
// Scoreboard for the converter sample normalizer: a cycle-free predictor of the
// rate limiter, min/max calibration and millivolt conversion. Depends on adcnorm_pkg.
package adcnorm_tb_pkg;
	import adcnorm_pkg::*;

	// Register indexes past the defined list must be ignored by the block.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_VREF_MV + 1);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] held;
		logic                captured;
		logic [NORM_W-1:0]   norm;
		logic                clipped;
		logic [VOLT_W-1:0]   voltage;
	} norm_result_t;

	class norm_scoreboard;
		// Register copies.
		logic [TS_W-1:0]     period;
		logic                auto_cal;
		logic [SAMPLE_W-1:0] fixed_min;
		logic [SAMPLE_W-1:0] fixed_max;
		logic [VREF_W-1:0]   vref;
		// Block state.
		logic [TS_W-1:0]     last_capture;
		logic [SAMPLE_W-1:0] held;
		logic [SAMPLE_W-1:0] run_min;
		logic [SAMPLE_W-1:0] run_max;

		norm_result_t expected[$];
		int errors;
		int readings;
		int captures;
		int clips;
		int auto_items;
		int reg_writes;

		function new();
			period       = '0;
			auto_cal     = 1'b0;
			fixed_min    = '0;
			fixed_max    = SAMPLE_W'(4095);
			vref         = VREF_W'(3300);
			last_capture = '0;
			held         = '0;
			run_min      = SAMPLE_W'(MIN_RST);
			run_max      = '0;
			errors       = 0;
			readings     = 0;
			captures     = 0;
			clips        = 0;
			auto_items   = 0;
			reg_writes   = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			reg_writes++;
			case (idx)
				REG_PERIOD_US: period = data[TS_W-1:0];
				REG_AUTO_CAL:  auto_cal = data[0];
				REG_FIXED_MIN: fixed_min = data[SAMPLE_W-1:0];
				REG_FIXED_MAX: fixed_max = data[SAMPLE_W-1:0];
				REG_VREF_MV:   vref = data[VREF_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [NORM_W-1:0] ratio_q16(logic [31:0] num, logic [31:0] den);
			if (den == 0)
				return '0;
			return NORM_W'((64'(num) << FRAC_W) / 64'(den));
		endfunction

		function void note_input(logic [TS_W-1:0] now, logic [SAMPLE_W-1:0] smp);
			norm_result_t r;
			logic [TS_W-1:0] elapsed;
			logic [BND_W-1:0] lo;
			logic [BND_W-1:0] hi;
			logic [63:0] volt;
			r = '0;
			readings++;
			elapsed = now - last_capture;
			if (elapsed >= period) begin
				last_capture = now;
				held = smp;
				r.captured = 1'b1;
				captures++;
			end
			if (auto_cal) begin
				auto_items++;
				if (held > run_max)
					run_max = held;
				if (held < run_min)
					run_min = held;
				if (run_max > run_min)
					r.norm = ratio_q16(held - run_min, run_max - run_min);
			end else begin
				lo = fixed_min;
				hi = fixed_max;
				if (lo >= hi) begin
					lo = '0;
					hi = BND_W'(FULL_SCALE);
				end
				if (held < lo) begin
					r.clipped = 1'b1;
				end else if (held > hi) begin
					r.norm = ONE_Q16;
					r.clipped = 1'b1;
				end else begin
					r.norm = ratio_q16(held - lo, hi - lo);
				end
				if (r.clipped)
					clips++;
			end
			volt = (64'(held) * 64'(vref)) / 64'(FULL_SCALE);
			if (volt > 64'hFFFF)
				volt = 64'hFFFF;
			r.held = held;
			r.voltage = volt[VOLT_W-1:0];
			expected.push_back(r);
		endfunction

		function void compare_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(norm_result_t got);
			norm_result_t want;
			if (expected.size() == 0) begin
				$error("result beat arrived with no reading outstanding");
				errors++;
				return;
			end
			want = expected.pop_front();
			compare_field("held_sample", want.held, got.held);
			compare_field("captured", want.captured, got.captured);
			compare_field("norm_q16", want.norm, got.norm);
			compare_field("clipped", want.clipped, got.clipped);
			compare_field("voltage_mv", want.voltage, got.voltage);
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

endpackage

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the normalizer testbench: clock, reset, beat drivers, result monitor
// and watchdog. Depends on adcnorm_pkg, adcnorm_ifs, adcnorm_tb_pkg and the RTL.
module tb_top;
	import adcnorm_pkg::*;
	import adcnorm_tb_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int QUIET_LIMIT   = 3000;
	localparam int PHASES        = 8;

	logic clk;
	logic arst_n;

	adcnorm_in_if  in_ch();
	adcnorm_out_if out_ch();
	adcnorm_cfg_if cfg_ch();

	adc_sample_autocal_normalizer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	norm_scoreboard sb;
	logic [TS_W-1:0] clock_us;
	int idle_pct;
	bit calm;
	int stall_left;
	int quiet_cycles;

	always #5 clk = ~clk;

	// Receiver side: random stall bursts, none once the run goes calm.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
			out_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 10);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_monitor
		norm_result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.held     = out_ch.held_sample;
			got.captured = out_ch.captured;
			got.norm     = out_ch.norm_q16;
			got.clipped  = out_ch.clipped;
			got.voltage  = out_ch.voltage_mv;
			sb.check_result(got);
		end
	end

	// A handshake stuck on every channel at once ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Leaves valid high after the beat so back-to-back readings need no low cycle.
	task automatic send_item(logic [TS_W-1:0] now, logic [SAMPLE_W-1:0] smp);
		@(negedge clk);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.now_us     <= now;
		in_ch.adc_sample <= smp;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(now, smp);
		clock_us = now;
	endtask

	// Stops the sender and waits until every result is back and the block is idle.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [TS_W-1:0] next_stamp();
		int pick;
		int span;
		pick = $urandom_range(0, 99);
		span = (sb.period <= 1000) ? int'(sb.period) * 2 + 2 : 2000;
		if (pick < 10)
			return $urandom;
		else if (pick < 25)
			return sb.last_capture + sb.period;
		else if (pick < 35)
			return sb.last_capture + sb.period - 1;
		return clock_us + TS_W'($urandom_range(0, span));
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SAMPLE_W'(SAMPLE_MAX);
			2: return sb.fixed_min + SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
			3: return sb.fixed_max + SAMPLE_W'($urandom_range(0, 2)) - 1'b1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic random_config(bit auto_mode);
		logic [TS_W-1:0] period;
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [VREF_W-1:0] vref;
		case ($urandom_range(0, 5))
			0: period = '0;
			1: period = $urandom_range(1, 20);
			2: period = $urandom_range(21, 500);
			3: period = $urandom;
			4: period = '1;
			default: period = $urandom_range(1000, 100000);
		endcase
		lo = SAMPLE_W'($urandom);
		hi = SAMPLE_W'($urandom);
		case ($urandom_range(0, 3))
			0: hi = lo;
			1: begin
				lo = '0;
				hi = '1;
			end
			2: if (lo > hi) begin
				lo = hi;
				hi = lo ^ hi ^ SAMPLE_W'($urandom);
			end
			default: ;
		endcase
		case ($urandom_range(0, 3))
			0: vref = '0;
			1: vref = '1;
			2: vref = VREF_W'(3300);
			default: vref = VREF_W'($urandom);
		endcase
		write_reg(REG_PERIOD_US, period);
		write_reg(REG_AUTO_CAL, CFG_DATA_W'(auto_mode));
		write_reg(REG_FIXED_MIN, CFG_DATA_W'(lo));
		write_reg(REG_FIXED_MAX, CFG_DATA_W'(hi));
		write_reg(REG_VREF_MV, CFG_DATA_W'(vref));
	endtask

	// With narrow set, samples start in a tight band around mid scale and widen,
	// so the running bounds move gradually instead of jumping to the rails.
	task automatic run_phase(int count, bit narrow, bit hold_mid);
		int k;
		int band;
		logic [SAMPLE_W-1:0] smp;
		for (k = 0; k < count; k++) begin
			band = (16 + k * 8 > 4000) ? 4000 : 16 + k * 8;
			if (narrow)
				smp = SAMPLE_W'(2048 - band / 2 + $urandom_range(0, band));
			else
				smp = pick_sample();
			send_item(next_stamp(), smp);
			if (hold_mid && k == count / 2)
				drain();
		end
		drain();
	endtask

	task automatic directed_part();
		logic [CFG_IDX_W-1:0] idx;
		// Power-on defaults: every reading captures, bounds are 0..full scale.
		send_item(32'h0000_0000, 12'h000);
		send_item(32'hFFFF_FFFF, 12'hFFF);
		send_item(32'h0000_0005, 12'd2048);
		send_item(32'h0000_0006, 12'hAAA);
		send_item(32'h0000_0007, 12'h555);
		drain();
		write_reg(REG_PERIOD_US, 32'd100);
		write_reg(REG_FIXED_MIN, 32'd1000);
		write_reg(REG_FIXED_MAX, 32'd3000);
		write_reg(REG_VREF_MV, 32'hFFFF);
		send_item(32'd1000, 12'd500);
		send_item(32'd1050, 12'd3500);
		send_item(32'd1100, 12'd3500);
		send_item(32'd1199, 12'd1000);
		send_item(32'd1200, 12'd1000);
		send_item(32'd1300, 12'd3000);
		// Timestamp wrap: the elapsed time is taken modulo 2^32.
		send_item(32'hFFFF_FFC0, 12'd2000);
		send_item(32'h0000_0020, 12'd2500);
		send_item(32'h0000_0024, 12'd2500);
		drain();
		// Inverted and equal bounds both fall back to the full range.
		write_reg(REG_FIXED_MIN, 32'd3000);
		write_reg(REG_FIXED_MAX, 32'd1000);
		write_reg(REG_VREF_MV, 32'd0);
		send_item(32'h0000_0088, 12'hFFF);
		drain();
		write_reg(REG_FIXED_MIN, 32'd2000);
		write_reg(REG_FIXED_MAX, 32'd2000);
		write_reg(REG_PERIOD_US, 32'hFFFF_FFFF);
		send_item(sb.last_capture + 1, 12'd1234);
		send_item(sb.last_capture + 32'hFFFF_FFFF, 12'd1234);
		drain();
		idx = REG_SPARE_FIRST;
		forever begin
			write_reg(idx, $urandom);
			if (idx == REG_SPARE_LAST)
				break;
			idx++;
		end
		write_reg(REG_PERIOD_US, 32'd0);
		write_reg(REG_AUTO_CAL, 32'd1);
		write_reg(REG_VREF_MV, 32'd3300);
		// First auto item sees min equal to max.
		send_item(clock_us + 1, 12'd2000);
		send_item(clock_us + 1, 12'd2000);
		send_item(clock_us + 1, 12'd2100);
		send_item(clock_us + 1, 12'd1900);
		send_item(clock_us + 1, 12'd2050);
		drain();
		write_reg(REG_AUTO_CAL, 32'd0);
		send_item(clock_us + 1, 12'd2050);
		drain();
		write_reg(REG_AUTO_CAL, 32'd1);
		send_item(clock_us + 1, 12'd1950);
		drain();
	endtask

	initial begin
		int p;
		clk              = 1'b0;
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.now_us     = '0;
		in_ch.adc_sample = '0;
		out_ch.ready     = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = '0;
		cfg_ch.data      = '0;
		clock_us         = '0;
		idle_pct         = 20;
		calm             = 1'b0;
		stall_left       = 0;
		quiet_cycles     = 0;
		sb = new();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		directed_part();
		for (p = 0; p < PHASES; p++) begin
			idle_pct = (p == 2) ? 0 : $urandom_range(10, 50);
			calm = (p == PHASES - 1);
			random_config((p == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
			run_phase(95 + $urandom_range(0, 20), p == 0, p == 3);
		end

		$display("Covered %0d readings: %0d captures, %0d clipped, %0d auto-calibrated.",
			sb.readings, sb.captures, sb.clips, sb.auto_items);
		$display("Register beats written: %0d, mismatches: %0d.", sb.reg_writes, sb.errors);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/adcnorm_pkg.sv
rtl/core/adcnorm_ifs.sv
rtl/core/adcnorm_front.sv
rtl/core/adcnorm_fifo.sv
rtl/core/adcnorm_back.sv
rtl/core/adc_sample_autocal_normalizer.sv
tb/sv/adcnorm_tb_pkg.sv
tb/sv/tb_top.sv
